// ===== rtl/core/hwl_pkg.sv =====
// Shared constants, coefficient tables and control types for the Hann-window lowpass.
package hwl_pkg;

    localparam int WINDOW_LEN  = 31;
    localparam int SAMPLE_BITS = 16;

    localparam int HALF_LEN  = WINDOW_LEN / 2;
    localparam int PHASE_W   = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int FILL_W    = $clog2(WINDOW_LEN + 1);
    localparam int Q_FRAC    = 14;
    localparam int TAB_W     = Q_FRAC + 2;
    localparam int DX_W      = SAMPLE_BITS + 1;
    localparam int R_W       = SAMPLE_BITS + FILL_W;
    localparam int C_W       = R_W + TAB_W - 1;
    localparam int ACC_W     = C_W + TAB_W;
    localparam int V_W       = C_W + 1;

    localparam int NORM_SHIFT = 24;
    localparam int NORM_DIV   = WINDOW_LEN + ((WINDOW_LEN == 1) ? 1 : 0);
    localparam int NORM       = ((1 << NORM_SHIFT) + NORM_DIV / 2) / NORM_DIV;
    localparam int NORM_W     = $clog2(NORM + 1);

    localparam int MA_W      = V_W;
    localparam int MB_W      = NORM_W + 1;
    localparam int P_W       = MA_W + MB_W;
    localparam int OUT_SHIFT = NORM_SHIFT + Q_FRAC;

    localparam int SMP_MAX = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int SMP_MIN = -(1 << (SAMPLE_BITS - 1));

    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint PI_Q30  = 64'sd3373259426;

    typedef logic [WINDOW_LEN-1:0][TAB_W-1:0] t_tab;

    typedef enum logic [2:0] {
        MS_DX_COS = 3'd0,
        MS_DX_SIN = 3'd1,
        MS_C_CK   = 3'd2,
        MS_S_SK   = 3'd3,
        MS_V_NRM  = 3'd4
    } t_mul_sel;

    typedef struct packed {
        logic     load;
        logic     upd_c;
        logic     upd_s;
        logic     acc_init;
        logic     acc_add;
        logic     load_out;
        t_mul_sel mul_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
    } t_dp_sts;

    function automatic longint div_trunc(longint num, longint den);
        longint un;
        longint ud;
        longint quo;
        longint rem;
        bit     neg;
        neg = (num < 0) ^ (den < 0);
        un  = (num < 0) ? -num : num;
        ud  = (den < 0) ? -den : den;
        quo = 0;
        rem = 0;
        for (int b = 62; b >= 0; b--) begin
            rem = (rem <<< 1) | ((un >>> b) & 64'sd1);
            quo = quo <<< 1;
            if (rem >= ud) begin
                rem = rem - ud;
                quo = quo | 64'sd1;
            end
        end
        return neg ? -quo : quo;
    endfunction

    function automatic longint mul_q30(longint a, longint b);
        return div_trunc(a * b, Q30_ONE);
    endfunction

    function automatic longint round_q14(longint v);
        if (v >= 0) begin
            return div_trunc(v + 64'sd32768, 64'sd65536);
        end
        return -div_trunc(-v + 64'sd32768, 64'sd65536);
    endfunction

    function automatic t_tab build_tab(bit want_sin);
        t_tab   tab;
        longint m;
        longint x;
        longint x2;
        longint ct;
        longint cs;
        longint st;
        longint ss;
        longint nc;
        longint ns;
        tab = '0;
        for (int i = 0; i < WINDOW_LEN; i++) begin
            m  = longint'(i - HALF_LEN);
            x  = div_trunc(PI_Q30 * m, 4 * longint'(WINDOW_LEN));
            x2 = mul_q30(x, x);
            ct = Q30_ONE;
            cs = Q30_ONE;
            st = x;
            ss = x;
            for (int k = 1; k <= 5; k++) begin
                ct = div_trunc(-mul_q30(ct, x2), longint'((2 * k - 1) * (2 * k)));
                cs = cs + ct;
                st = div_trunc(-mul_q30(st, x2), longint'((2 * k) * (2 * k + 1)));
                ss = ss + st;
            end
            for (int d = 0; d < 3; d++) begin
                nc = 2 * mul_q30(cs, cs) - Q30_ONE;
                ns = 2 * mul_q30(ss, cs);
                cs = nc;
                ss = ns;
            end
            tab[i] = want_sin ? TAB_W'(round_q14(ss)) : TAB_W'(round_q14(cs));
        end
        return tab;
    endfunction

    localparam t_tab COS_TAB = build_tab(1'b0);
    localparam t_tab SIN_TAB = build_tab(1'b1);

endpackage

// ===== rtl/core/hwl_ctl.sv =====
// Sequencing state machine for the Hann-window lowpass datapath and output beat.
module hwl_ctl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  hwl_pkg::t_dp_sts i_sts,
    output hwl_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [7:0] {
        ST_IDLE    = 8'b0000_0001,
        ST_MUL_COS = 8'b0000_0010,
        ST_MUL_SIN = 8'b0000_0100,
        ST_MUL_CK  = 8'b0000_1000,
        ST_MUL_SK  = 8'b0001_0000,
        ST_SUM     = 8'b0010_0000,
        ST_MUL_NRM = 8'b0100_0000,
        ST_OUT     = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_vld;
    logic   n_out_vld;
    logic   slot_free;

    assign slot_free   = !r_out_vld || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_vld;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.mul_sel = hwl_pkg::MS_DX_COS;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL_COS;
                end
            end
            ST_MUL_COS: begin
                o_cmd.mul_sel = hwl_pkg::MS_DX_COS;
                n_state       = ST_MUL_SIN;
            end
            ST_MUL_SIN: begin
                o_cmd.upd_c   = 1'b1;
                o_cmd.mul_sel = hwl_pkg::MS_DX_SIN;
                n_state       = ST_MUL_CK;
            end
            ST_MUL_CK: begin
                o_cmd.upd_s   = 1'b1;
                o_cmd.mul_sel = hwl_pkg::MS_C_CK;
                n_state       = i_sts.full ? ST_MUL_SK : ST_IDLE;
            end
            ST_MUL_SK: begin
                o_cmd.acc_init = 1'b1;
                o_cmd.mul_sel  = hwl_pkg::MS_S_SK;
                n_state        = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.acc_add = 1'b1;
                n_state       = ST_MUL_NRM;
            end
            ST_MUL_NRM: begin
                o_cmd.mul_sel = hwl_pkg::MS_V_NRM;
                n_state       = ST_OUT;
            end
            ST_OUT: begin
                o_cmd.mul_sel = hwl_pkg::MS_V_NRM;
                if (slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (o_cmd.load_out) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

endmodule

// ===== rtl/core/hwl_dp.sv =====
// Datapath: delay line, running sums, shared multiplier, rounding and saturation.
module hwl_dp (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  hwl_pkg::t_dp_cmd                        i_cmd,
    output hwl_pkg::t_dp_sts                        o_sts,
    input  logic signed [hwl_pkg::SAMPLE_BITS-1:0]  i_sample,
    input  logic                                    i_restart,
    output logic signed [hwl_pkg::SAMPLE_BITS-1:0]  o_filtered
);

    localparam int SB = hwl_pkg::SAMPLE_BITS;
    localparam int PW = hwl_pkg::PHASE_W;

    localparam logic signed [hwl_pkg::ACC_W-1:0] ACC_BIAS =
        hwl_pkg::ACC_W'(1) <<< (hwl_pkg::Q_FRAC - 1);
    localparam logic signed [hwl_pkg::P_W-1:0] OUT_BIAS =
        hwl_pkg::P_W'(1) <<< (hwl_pkg::OUT_SHIFT - 1);
    localparam logic signed [hwl_pkg::P_W-1:0] Y_MAX = hwl_pkg::P_W'(hwl_pkg::SMP_MAX);
    localparam logic signed [hwl_pkg::P_W-1:0] Y_MIN = hwl_pkg::P_W'(hwl_pkg::SMP_MIN);

    logic signed [SB-1:0]                r_line [hwl_pkg::WINDOW_LEN];
    logic signed [SB-1:0]                r_old;
    logic [PW-1:0]                       r_phase;
    logic [PW-1:0]                       r_pcur;
    logic [hwl_pkg::FILL_W-1:0]          r_fill;
    logic                                r_full;
    logic signed [hwl_pkg::R_W-1:0]      r_r;
    logic signed [hwl_pkg::C_W-1:0]      r_c;
    logic signed [hwl_pkg::C_W-1:0]      r_s;
    logic signed [hwl_pkg::DX_W-1:0]     r_dx;
    logic signed [hwl_pkg::P_W-1:0]      r_prod;
    logic signed [hwl_pkg::ACC_W-1:0]    r_acc;
    logic signed [SB-1:0]                r_filtered;

    logic [PW-1:0]                       eff_p;
    logic [hwl_pkg::FILL_W-1:0]          eff_fill;
    logic                                eff_full;
    logic signed [hwl_pkg::R_W-1:0]      eff_r;
    logic signed [SB-1:0]                old_smp;
    logic signed [hwl_pkg::DX_W-1:0]     dx;
    logic [hwl_pkg::FILL_W-1:0]          fill_inc;
    logic [PW-1:0]                       p_next;
    logic [PW:0]                         j_sum;
    logic [PW-1:0]                       j_idx;
    logic signed [hwl_pkg::MA_W-1:0]     mul_a;
    logic signed [hwl_pkg::MB_W-1:0]     mul_b;
    logic signed [hwl_pkg::P_W-1:0]      y_full;
    logic signed [SB-1:0]                y_sat;

    always_comb begin
        eff_p    = i_restart ? '0 : r_phase;
        eff_fill = i_restart ? '0 : r_fill;
        eff_full = i_restart ? 1'b0 : r_full;
        eff_r    = i_restart ? '0 : r_r;
        old_smp  = eff_full ? r_old : '0;
        dx       = hwl_pkg::DX_W'(i_sample) - hwl_pkg::DX_W'(old_smp);
        fill_inc = eff_fill + 1'b1;
        p_next   = (eff_p == PW'(hwl_pkg::WINDOW_LEN - 1)) ? '0 : eff_p + 1'b1;
        j_sum    = {1'b0, r_pcur} + (PW + 1)'(hwl_pkg::HALF_LEN + 1);
        j_idx    = (j_sum >= (PW + 1)'(hwl_pkg::WINDOW_LEN))
                 ? PW'(j_sum - (PW + 1)'(hwl_pkg::WINDOW_LEN)) : PW'(j_sum);
    end

    always_comb begin
        case (i_cmd.mul_sel)
            hwl_pkg::MS_DX_COS: begin
                mul_a = hwl_pkg::MA_W'(r_dx);
                mul_b = hwl_pkg::MB_W'($signed(hwl_pkg::COS_TAB[r_pcur]));
            end
            hwl_pkg::MS_DX_SIN: begin
                mul_a = hwl_pkg::MA_W'(r_dx);
                mul_b = hwl_pkg::MB_W'($signed(hwl_pkg::SIN_TAB[r_pcur]));
            end
            hwl_pkg::MS_C_CK: begin
                mul_a = hwl_pkg::MA_W'(r_c);
                mul_b = hwl_pkg::MB_W'($signed(hwl_pkg::COS_TAB[j_idx]));
            end
            hwl_pkg::MS_S_SK: begin
                mul_a = hwl_pkg::MA_W'(r_s);
                mul_b = hwl_pkg::MB_W'($signed(hwl_pkg::SIN_TAB[j_idx]));
            end
            hwl_pkg::MS_V_NRM: begin
                mul_a = $signed(r_acc[hwl_pkg::Q_FRAC +: hwl_pkg::V_W]);
                mul_b = hwl_pkg::MB_W'(hwl_pkg::NORM);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        y_full = (r_prod + OUT_BIAS) >>> hwl_pkg::OUT_SHIFT;
        if (y_full > Y_MAX) begin
            y_sat = SB'(Y_MAX);
        end else if (y_full < Y_MIN) begin
            y_sat = SB'(Y_MIN);
        end else begin
            y_sat = SB'(y_full);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_pcur  <= '0;
            r_fill  <= '0;
            r_full  <= 1'b0;
            r_r     <= '0;
            r_c     <= '0;
            r_s     <= '0;
        end else begin
            if (i_cmd.load) begin
                r_phase <= p_next;
                r_pcur  <= eff_p;
                r_r     <= eff_r + hwl_pkg::R_W'(dx);
                if (i_restart) begin
                    r_c <= '0;
                    r_s <= '0;
                end
                if (!eff_full) begin
                    r_fill <= fill_inc;
                    r_full <= (fill_inc >= hwl_pkg::FILL_W'(hwl_pkg::WINDOW_LEN));
                end else begin
                    r_fill <= eff_fill;
                    r_full <= 1'b1;
                end
            end
            if (i_cmd.upd_c) begin
                r_c <= r_c + $signed(r_prod[hwl_pkg::C_W-1:0]);
            end
            if (i_cmd.upd_s) begin
                r_s <= r_s + $signed(r_prod[hwl_pkg::C_W-1:0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        r_old  <= r_line[r_phase];
        if (i_cmd.load) begin
            r_line[eff_p] <= i_sample;
            r_dx          <= dx;
        end
        if (i_cmd.acc_init) begin
            r_acc <= $signed(r_prod[hwl_pkg::ACC_W-1:0]) + ACC_BIAS
                   + (hwl_pkg::ACC_W'(r_r) <<< (2 * hwl_pkg::Q_FRAC));
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + $signed(r_prod[hwl_pkg::ACC_W-1:0]);
        end
        if (i_cmd.load_out) begin
            r_filtered <= y_sat;
        end
    end

    assign o_sts.full = r_full;
    assign o_filtered = r_filtered;

endmodule

// ===== rtl/core/hann_window_lowpass_top.sv =====
// An accepted sample steps through MUL_COS, MUL_SIN and MUL_CK; once the window is full
// it goes on through MUL_SK, SUM, MUL_NRM and OUT, which registers its result beat. The
// next sample waits for idle. One registered 37x21 multiplier serves five products.
// A waiting result beat stalls the next item only when it reaches the output step.
// Reset (i_rst_n low, synchronous) empties the window and clears sums and phase; the
// delay line is not cleared, since an entry is read only after a write since restart.
module hann_window_lowpass_top (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic signed [hwl_pkg::SAMPLE_BITS-1:0]  i_sample,
    input  logic                                    i_restart,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [hwl_pkg::SAMPLE_BITS-1:0]  o_filtered
);

    hwl_pkg::t_dp_cmd cmd;
    hwl_pkg::t_dp_sts sts;

    hwl_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    hwl_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_sample   (i_sample),
        .i_restart  (i_restart),
        .o_filtered (o_filtered)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while datapath busy");

    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.load_out))
        else $error("result beat raised without an output load");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_out_valid || i_out_ready))
        else $error("pending result beat overwritten");

    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> (o_in_ready && i_in_valid && !cmd.upd_c && !cmd.acc_add))
        else $error("sample load outside an accept");

endmodule
